### design/assert_macros.svh
// Assertion macros for the allocator datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define PIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset
`define PIA_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### design/pia_pkg.sv
// Types and constants shared by the probed id allocator modules
package pia_pkg;

    localparam int PENDING_SLOTS  = 16;
    localparam int ID_BITS        = 16;
    localparam int TAG_BITS       = 32;
    localparam int SLOT_BITS      = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int IN_DATA_BITS   = ((TAG_BITS + 1 + ID_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((ID_BITS + TAG_BITS + 7) / 8) * 8;

    localparam logic [ID_BITS-1:0] FIRST_ID_RESET = ID_BITS'(1);
    localparam logic [ID_BITS-1:0] LAST_ID_RESET  = ID_BITS'(65535);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_ID = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_ID  = CFG_INDEX_BITS'(1);

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_PONG    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_NONE   = 3'd0,
        OUT_DUP    = 3'd1,
        OUT_PROBE  = 3'd2,
        OUT_ASSIGN = 3'd3,
        OUT_NOFREE = 3'd4,
        OUT_FULL   = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        KEY_ITEM   = 2'd0,
        KEY_CAND   = 2'd1,
        KEY_CHOSEN = 2'd2
    } key_sel_t;

    typedef struct packed {
        logic     load_item;
        key_sel_t key_sel;
        logic     clear_hits;
        logic     res_load;
        outcome_t res_outcome;
        logic     load_chosen_ident;
        logic     load_chosen_cand;
        logic     step_ptr;
        logic     load_tries;
        logic     dec_tries;
        logic     write_entry;
        logic     emit;
    } pia_cmd_t;

    typedef struct packed {
        op_t  op;
        logic specific;
        logic tag_hit;
        logic id_hit;
        logic tries_zero;
        logic free_avail;
        logic out_free;
    } pia_stat_t;

endpackage

### design/probed_id_allocator.sv
// Probed id allocator: pending probe table with duplicate check and wrapping id search
//
// Input beats arrive on s_*: tuser carries the op (acquire, pong, timeout), tdata the
// request tag, the wants-specific flag and the id. Every beat yields exactly one
// result beat on m_*: tuser is the outcome, tdata the id and the tag.
// Configuration: cfg_we/cfg_index/cfg_data write first_id (index 0) or last_id (1);
// write only while no beat is in flight.
// One item is worked on at a time. Pong, timeout, unused op and duplicate acquires
// pass from accept through evaluate to emit, where the result is loaded into the output
// register. An acquire for a given id adds a commit step. A searching acquire
// tries candidate ids before the commit: at most PENDING_SLOTS + 1 tries (17), or fewer
// when the id range is smaller. The search checks one candidate per cycle against all
// pending slots in parallel. The result sits in an output register; the next beat is
// taken while it waits, but a further result holds in the block until m_tready takes
// the previous one. Reset empties the pending table, sets first_id to 1, last_id to
// all ones and the search pointer to 1; no clearing pass is needed.
module probed_id_allocator
    import pia_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // request_tag, wants_specific, ident, zero pad
    input  logic [1:0]                s_tuser,   // op
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // out_id, out_tag
    output logic [2:0]                m_tuser    // outcome
);

    pia_cmd_t            cmd;
    pia_stat_t           stat;
    outcome_t            out_outcome;
    logic [ID_BITS-1:0]  out_id;
    logic [TAG_BITS-1:0] out_tag;

    pia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pia_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser),
        .in_tag      (s_tdata[TAG_BITS-1:0]),
        .in_specific (s_tdata[TAG_BITS]),
        .in_ident    (s_tdata[TAG_BITS+ID_BITS:TAG_BITS+1]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_outcome (out_outcome),
        .out_id      (out_id),
        .out_tag     (out_tag)
    );

    assign m_tdata = OUT_DATA_BITS'({out_tag, out_id});
    assign m_tuser = out_outcome;

endmodule

### design/pia_ctrl.sv
// Sequencer for the probed id allocator: evaluate, search, commit, emit
module pia_ctrl
    import pia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pia_stat_t stat,
    output pia_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.key_sel = KEY_ITEM;
                unique case (stat.op)
                    OP_PONG:
                    begin
                        cmd.clear_hits  = 1'b1;
                        cmd.res_load    = 1'b1;
                        cmd.res_outcome = OUT_NONE;
                        state_next      = ST_EMIT;
                    end
                    OP_TIMEOUT:
                    begin
                        cmd.clear_hits  = 1'b1;
                        cmd.res_load    = 1'b1;
                        cmd.res_outcome = stat.id_hit ? OUT_ASSIGN : OUT_NONE;
                        state_next      = ST_EMIT;
                    end
                    OP_ACQUIRE:
                    begin
                        priority if (stat.tag_hit)
                        begin
                            cmd.res_load    = 1'b1;
                            cmd.res_outcome = OUT_DUP;
                            state_next      = ST_EMIT;
                        end
                        else if (stat.specific)
                        begin
                            cmd.load_chosen_ident = 1'b1;
                            state_next            = ST_COMMIT;
                        end
                        else
                        begin
                            cmd.load_tries = 1'b1;
                            state_next     = ST_SEARCH;
                        end
                    end
                    OP_UNUSED:
                    begin
                        cmd.res_load    = 1'b1;
                        cmd.res_outcome = OUT_NONE;
                        state_next      = ST_EMIT;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                // one candidate per cycle; pointer moves on every try
                cmd.key_sel  = KEY_CAND;
                cmd.step_ptr = 1'b1;
                priority if (!stat.id_hit)
                begin
                    cmd.load_chosen_cand = 1'b1;
                    state_next           = ST_COMMIT;
                end
                else if (stat.tries_zero)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_outcome = OUT_NOFREE;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.dec_tries = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                cmd.key_sel  = KEY_CHOSEN;
                cmd.res_load = 1'b1;
                if (stat.id_hit || stat.free_avail)
                begin
                    cmd.write_entry = 1'b1;
                    cmd.res_outcome = OUT_PROBE;
                end
                else
                begin
                    cmd.res_outcome = OUT_FULL;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/pia_dp.sv
// Datapath: config registers, pending table, search pointer, result and output registers
module pia_dp
    import pia_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [1:0]                in_op,
    input  logic [TAG_BITS-1:0]       in_tag,
    input  logic                      in_specific,
    input  logic [ID_BITS-1:0]        in_ident,
    input  pia_cmd_t                  cmd,
    output pia_stat_t                 stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output outcome_t                  out_outcome,
    output logic [ID_BITS-1:0]        out_id,
    output logic [TAG_BITS-1:0]       out_tag
);

    `include "assert_macros.svh"

    logic [ID_BITS-1:0]       first_id_reg, last_id_reg, cand_reg, cand_next;
    logic [ID_BITS-1:0]       remaining_reg, chosen_reg, ident_reg;
    op_t                      op_reg;
    logic [TAG_BITS-1:0]      tag_reg;
    logic                     spec_reg;
    logic [PENDING_SLOTS-1:0] valid_reg, valid_next;
    logic [ID_BITS-1:0]       entry_id_reg  [PENDING_SLOTS];
    logic [TAG_BITS-1:0]      entry_tag_reg [PENDING_SLOTS];

    outcome_t                 res_outcome_reg, out_outcome_reg;
    logic [ID_BITS-1:0]       res_id_reg, out_id_reg, res_id_next;
    logic [TAG_BITS-1:0]      res_tag_reg, out_tag_reg, res_tag_next;
    logic                     out_valid_reg;

    logic [ID_BITS-1:0]       key;
    logic [PENDING_SLOTS-1:0] id_match, tag_match;
    logic [SLOT_BITS-1:0]     hit_slot, free_slot, wr_slot;
    logic                     id_hit, free_avail, out_free;
    logic [TAG_BITS-1:0]      hit_tag;

    always_comb
    begin
        unique case (cmd.key_sel)
            KEY_ITEM:   key = ident_reg;
            KEY_CAND:   key = cand_reg;
            KEY_CHOSEN: key = chosen_reg;
            default:    key = ident_reg;
        endcase
    end

    // one comparator lane per slot
    always_comb
    begin
        for (int i = 0; i < PENDING_SLOTS; i++)
        begin
            id_match[i]  = valid_reg[i] && (entry_id_reg[i] == key);
            tag_match[i] = valid_reg[i] && (entry_tag_reg[i] == tag_reg);
        end
    end

    // lowest matching and lowest free slot
    always_comb
    begin
        hit_slot  = '0;
        free_slot = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--)
        begin
            if (id_match[i])
            begin
                hit_slot = SLOT_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    assign id_hit     = |id_match;
    assign free_avail = ~&valid_reg;
    assign hit_tag    = entry_tag_reg[hit_slot];
    assign wr_slot    = id_hit ? hit_slot : free_slot;
    assign out_free   = !out_valid_reg || out_ready;
    assign cand_next  = (cand_reg == last_id_reg) ? first_id_reg : cand_reg + ID_BITS'(1);

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_hits)
        begin
            valid_next = valid_reg & ~id_match;
        end
        if (cmd.write_entry)
        begin
            valid_next[wr_slot] = 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.res_outcome)
            OUT_ASSIGN:          res_id_next = ident_reg;
            OUT_PROBE, OUT_FULL: res_id_next = chosen_reg;
            default:             res_id_next = '0;
        endcase
        unique case (cmd.res_outcome)
            OUT_ASSIGN: res_tag_next = hit_tag;
            OUT_NONE:   res_tag_next = '0;
            default:    res_tag_next = tag_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg  <= FIRST_ID_RESET;
            last_id_reg   <= LAST_ID_RESET;
            cand_reg      <= FIRST_ID_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_FIRST_ID))
            begin
                first_id_reg <= ID_BITS'(cfg_data);
            end
            if (cfg_we && (cfg_index == CFG_LAST_ID))
            begin
                last_id_reg <= ID_BITS'(cfg_data);
            end
            if (cmd.step_ptr)
            begin
                cand_reg <= cand_next;
            end
            valid_reg <= valid_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= op_t'(in_op);
            tag_reg   <= in_tag;
            spec_reg  <= in_specific;
            ident_reg <= in_ident;
        end
        if (cmd.load_chosen_ident)
        begin
            chosen_reg <= ident_reg;
        end
        else if (cmd.load_chosen_cand)
        begin
            chosen_reg <= cand_reg;
        end
        if (cmd.load_tries)
        begin
            remaining_reg <= last_id_reg - first_id_reg;
        end
        else if (cmd.dec_tries)
        begin
            remaining_reg <= remaining_reg - ID_BITS'(1);
        end
        if (cmd.write_entry)
        begin
            entry_id_reg[wr_slot]  <= chosen_reg;
            entry_tag_reg[wr_slot] <= tag_reg;
        end
        if (cmd.res_load)
        begin
            res_outcome_reg <= cmd.res_outcome;
            res_id_reg      <= res_id_next;
            res_tag_reg     <= res_tag_next;
        end
        if (cmd.emit)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_id_reg      <= res_id_reg;
            out_tag_reg     <= res_tag_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.specific   = spec_reg;
    assign stat.tag_hit    = |tag_match;
    assign stat.id_hit     = id_hit;
    assign stat.tries_zero = (remaining_reg == '0);
    assign stat.free_avail = free_avail;
    assign stat.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign out_outcome = out_outcome_reg;
    assign out_id      = out_id_reg;
    assign out_tag     = out_tag_reg;

    `PIA_ASSERT(a_id_unique, $onehot0(id_match), "pending id held by two slots")
    `PIA_ASSERT(a_emit_free, cmd.emit |-> out_free, "result emitted over an untaken beat")
    `PIA_ASSERT_NEVER(a_write_no_slot, cmd.write_entry && !id_hit && !free_avail,
        "entry written with no slot to take")

endmodule

### tb/tb_probed_id_allocator.sv
// Self-checking testbench for the probed id allocator: directed rows, then random traffic
module tb_probed_id_allocator;
    import pia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_BEATS   = 220;
    localparam int unsigned SETTLE_CYCLES = 30;

    typedef struct packed {
        op_t                 op;
        logic [TAG_BITS-1:0] tag;
        logic                spec;
        logic [ID_BITS-1:0]  ident;
    } req_t;

    typedef struct packed {
        outcome_t            outcome;
        logic [ID_BITS-1:0]  id;
        logic [TAG_BITS-1:0] tag;
    } res_t;

    typedef struct {
        bit   pinned;
        res_t res;
    } pin_t;

    typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        req_t                      req;
        int unsigned               reps;
        bit                        pinned;
        res_t                      res;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
    } plan_row_t;

    typedef enum bit [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata = '0;   // request_tag, wants_specific, ident, zero pad
    logic [1:0]                s_tuser = '0;   // op
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;        // out_id, out_tag
    logic [2:0]                m_tuser;        // outcome

    // allocator state as the testbench sees it
    logic [ID_BITS-1:0]  cfg_first = FIRST_ID_RESET;
    logic [ID_BITS-1:0]  cfg_last = LAST_ID_RESET;
    logic [ID_BITS-1:0]  search_ptr = FIRST_ID_RESET;
    bit                  pend_valid [PENDING_SLOTS];
    logic [ID_BITS-1:0]  pend_id [PENDING_SLOTS];
    logic [TAG_BITS-1:0] pend_tag [PENDING_SLOTS];

    res_t        awaited_results[$];
    pin_t        fixed_results[$];
    bit          hold_req = 1'b0;
    int unsigned n_errors = 0;
    int unsigned n_in = 0;
    int unsigned n_holds = 0;
    int unsigned n_seen [8];

    probed_id_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic int slot_of_id(logic [ID_BITS-1:0] id);
        for (int i = 0; i < PENDING_SLOTS; i++)
            if (pend_valid[i] && pend_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic res_t alloc_step(req_t r);
        res_t               res;
        int                 slot;
        logic [ID_BITS-1:0] chosen;
        logic [ID_BITS-1:0] span;
        bit                 found;
        int unsigned        tries;
        int unsigned        n;
        res = '{OUT_NONE, '0, '0};
        case (r.op)
            OP_PONG:
                for (int i = 0; i < PENDING_SLOTS; i++)
                    if (pend_valid[i] && pend_id[i] == r.ident)
                        pend_valid[i] = 1'b0;
            OP_TIMEOUT:
            begin
                slot = slot_of_id(r.ident);
                if (slot >= 0)
                begin
                    res = '{OUT_ASSIGN, r.ident, pend_tag[slot]};
                    pend_valid[slot] = 1'b0;
                end
            end
            OP_ACQUIRE:
            begin
                for (int i = 0; i < PENDING_SLOTS; i++)
                    if (pend_valid[i] && pend_tag[i] == r.tag)
                        return '{OUT_DUP, '0, r.tag};
                chosen = r.ident;
                found = r.spec;
                span = cfg_last - cfg_first;
                tries = span + 1;
                n = 0;
                // pointer wraps to first_id only on hitting last_id
                while (!found && n < tries)
                begin
                    chosen = search_ptr;
                    search_ptr = (search_ptr == cfg_last) ? cfg_first : search_ptr + 1'b1;
                    found = (slot_of_id(chosen) < 0);
                    n++;
                end
                if (!found)
                    return '{OUT_NOFREE, '0, r.tag};
                slot = slot_of_id(chosen);
                if (slot < 0)
                    for (int i = PENDING_SLOTS - 1; i >= 0; i--)
                        if (!pend_valid[i])
                            slot = i;
                if (slot < 0)
                    return '{OUT_FULL, chosen, r.tag};
                pend_valid[slot] = 1'b1;
                pend_id[slot] = chosen;
                pend_tag[slot] = r.tag;
                res = '{OUT_PROBE, chosen, r.tag};
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int any_pending_slot();
        int live[$];
        foreach (pend_valid[i])
            if (pend_valid[i])
                live.insert(live.size(), i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // mostly well-formed traffic: pongs and timeouts aimed at live ids, some tag reuse
    function automatic req_t random_req();
        req_t               r;
        int                 slot;
        int unsigned        pick;
        logic [ID_BITS-1:0] span;
        pick = $urandom_range(0, 99);
        r.tag = $urandom();
        r.spec = 1'($urandom_range(0, 1));
        r.ident = ID_BITS'($urandom_range(0, 65535));
        span = cfg_last - cfg_first;
        if (pick < 50)
        begin
            r.op = OP_ACQUIRE;
            r.spec = ($urandom_range(0, 9) < 3);
            slot = any_pending_slot();
            if (slot >= 0 && $urandom_range(0, 7) == 0)
                r.tag = pend_tag[slot];
            slot = any_pending_slot();
            case ($urandom_range(0, 2))
                0: if (slot >= 0) r.ident = pend_id[slot];
                1: r.ident = cfg_first + ID_BITS'($urandom_range(0, span));
                default: ;
            endcase
        end
        else if (pick < 96)
        begin
            r.op = (pick < 72) ? OP_PONG : OP_TIMEOUT;
            slot = any_pending_slot();
            if (slot >= 0 && $urandom_range(0, 3) != 0)
                r.ident = pend_id[slot];
        end
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    function automatic plan_row_t beat_row(op_t op, logic [TAG_BITS-1:0] tag, logic spec,
                                           logic [ID_BITS-1:0] ident, int unsigned reps);
        plan_row_t row;
        row.kind = ROW_BEAT;
        row.req = '{op, tag, spec, ident};
        row.reps = reps;
        row.pinned = 1'b0;
        row.res = '{OUT_NONE, '0, '0};
        row.reg_idx = '0;
        return row;
    endfunction

    function automatic plan_row_t pinned_row(op_t op, logic [TAG_BITS-1:0] tag, logic spec,
                                             logic [ID_BITS-1:0] ident, outcome_t oc,
                                             logic [ID_BITS-1:0] oid,
                                             logic [TAG_BITS-1:0] otag);
        plan_row_t row;
        row = beat_row(op, tag, spec, ident, 1);
        row.pinned = 1'b1;
        row.res = '{oc, oid, otag};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                          logic [ID_BITS-1:0] val);
        plan_row_t row;
        row = beat_row(OP_UNUSED, '0, 1'b0, val, 0);
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        return row;
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("%s", msg);
    endtask

    task automatic send_beat(input req_t r, input bit pinned, input res_t want);
        fixed_results.insert(fixed_results.size(), '{pinned, want});
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= IN_DATA_BITS'({r.ident, r.spec, r.tag});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // scoreboard: check the result beat first, then predict the accepted input beat
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        req_t seen;
        pin_t pin;
        res_t pred;
        if (m_tvalid && m_tready)
        begin
            got.outcome = outcome_t'(m_tuser);
            got.id = m_tdata[ID_BITS-1:0];
            got.tag = m_tdata[ID_BITS+TAG_BITS-1:ID_BITS];
            n_seen[m_tuser]++;
            if (awaited_results.size() == 0)
                report_error($sformatf("unexpected result: outcome %0d id %h tag %h",
                                       m_tuser, got.id, got.tag));
            else
            begin
                want = awaited_results.pop_front();
                if (got.outcome != want.outcome || got.id != want.id || got.tag != want.tag)
                    report_error($sformatf(
                        "mismatch: outcome exp %0d got %0d, id exp %h got %h, tag exp %h got %h",
                        want.outcome, m_tuser, want.id, got.id, want.tag, got.tag));
            end
        end
        if (cfg_we)
        begin
            if (cfg_index == CFG_FIRST_ID)
                cfg_first = cfg_data;
            else if (cfg_index == CFG_LAST_ID)
                cfg_last = cfg_data;
        end
        if (s_tvalid && s_tready)
        begin
            seen.op = op_t'(s_tuser);
            seen.tag = s_tdata[TAG_BITS-1:0];
            seen.spec = s_tdata[TAG_BITS];
            seen.ident = s_tdata[TAG_BITS+ID_BITS:TAG_BITS+1];
            pred = alloc_step(seen);
            pin = fixed_results.pop_front();
            awaited_results.insert(awaited_results.size(), pin.pinned ? pin.res : pred);
            n_in++;
        end
    end

    // receiver: ready pattern switches among random modes; long hold on request
    initial
    begin
        rx_mode_t    mode;
        int unsigned left;
        mode = RX_OPEN;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                n_holds++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (left % 8 < 5);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        plan_row_t          plan[$];
        req_t               req;
        int unsigned        burst_left;
        int unsigned        k;
        int unsigned        a;
        logic [ID_BITS-1:0] lo;
        logic [ID_BITS-1:0] hi;

        plan.insert(plan.size(), pinned_row(OP_UNUSED, '1, 1'b1, '1, OUT_NONE, '0, '0));
        plan.insert(plan.size(), pinned_row(OP_PONG, '0, 1'b0, '0, OUT_NONE, '0, '0));
        plan.insert(plan.size(), pinned_row(OP_TIMEOUT, '1, 1'b1, '1, OUT_NONE, '0, '0));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, '0, 1'b0, '0, OUT_PROBE, 16'd1, '0));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, '0, 1'b1, 16'd7, OUT_DUP, '0, '0));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, '1, 1'b1, '1, OUT_PROBE, '1, '1));
        // requested id already pending: tag replaced, probed again
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, 32'd5, 1'b1, '1, OUT_PROBE, '1, 32'd5));
        plan.insert(plan.size(), pinned_row(OP_TIMEOUT, '0, 1'b0, '1, OUT_ASSIGN, '1, 32'd5));
        plan.insert(plan.size(), pinned_row(OP_PONG, '0, 1'b0, 16'd1, OUT_NONE, '0, '0));
        // range wrapping through zero; pointer sits on last_id so it re-enters the range
        plan.insert(plan.size(), cfg_row(CFG_FIRST_ID, 16'hfffe));
        plan.insert(plan.size(), cfg_row(CFG_LAST_ID, 16'd2));
        plan.insert(plan.size(), beat_row(OP_ACQUIRE, 32'h10, 1'b0, '0, 5));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, 32'h20, 1'b0, '0, OUT_NOFREE, '0,
                                            32'h20));
        plan.insert(plan.size(), beat_row(OP_ACQUIRE, 32'h100, 1'b1, 16'h8000, 11));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, 32'h200, 1'b1, 16'h9000,
                                            OUT_FULL, 16'h9000, 32'h200));
        plan.insert(plan.size(), pinned_row(OP_ACQUIRE, 32'h300, 1'b1, 16'h8000,
                                            OUT_PROBE, 16'h8000, 32'h300));
        plan.insert(plan.size(), pinned_row(OP_TIMEOUT, '0, 1'b0, 16'h8000,
                                            OUT_ASSIGN, 16'h8000, 32'h300));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].req.ident);
            end
            else
                for (int unsigned rep = 0; rep < plan[i].reps; rep++)
                begin
                    req = plan[i].req;
                    req.tag = req.tag + TAG_BITS'(rep);
                    req.ident = req.ident + ID_BITS'(rep);
                    send_beat(req, plan[i].pinned, plan[i].res);
                end
        end

        burst_left = 0;
        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase == 0)
            begin
                lo = '0;
                hi = '1;
            end
            else if (phase == PHASES - 1)
            begin
                lo = '1;
                hi = '0;
            end
            else
            begin
                // range placed around the search pointer so the wrap is reached
                k = (phase == 1) ? $urandom_range(0, 3) : $urandom_range(0, 24);
                a = $urandom_range(0, k);
                lo = search_ptr - ID_BITS'(a);
                hi = lo + ID_BITS'(k);
            end
            write_reg(CFG_FIRST_ID, lo);
            write_reg(CFG_LAST_ID, hi);
            if (phase == 2 || phase == 5)
            begin
                hold_req = 1'b1;
                burst_left = 40;
            end
            for (int unsigned n = 0; n < PHASE_BEATS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        pause_sender($urandom_range(1, 10));
                end
                burst_left--;
                send_beat(random_req(), 1'b0, '{OUT_NONE, '0, '0});
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_error($sformatf("%0d results never arrived", awaited_results.size()));

        $display("covered %0d input beats over %0d id ranges, %0d long output holds",
                 n_in, PHASES + 2, n_holds);
        $display("outcomes: none %0d, dup %0d, probe %0d, assign %0d, no free %0d, full %0d",
                 n_seen[OUT_NONE], n_seen[OUT_DUP], n_seen[OUT_PROBE], n_seen[OUT_ASSIGN],
                 n_seen[OUT_NOFREE], n_seen[OUT_FULL]);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pia_pkg.sv
design/pia_ctrl.sv
design/pia_dp.sv
design/probed_id_allocator.sv
tb/tb_probed_id_allocator.sv
